// ----- rtl/core/vfsd_pkg.sv -----
// vfsd_pkg: shared constants and helper functions for the vsync frame skip divider.
// Depends on nothing; used by vfsd_divider and vsync_frame_skip_divider.
`timescale 1ns / 1ps
package vfsd_pkg;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned RATE_W = 7;
	localparam int unsigned SKIP_W = 5;
	localparam int unsigned PREF_W = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PREFERRED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANIMATE = 1'd1;
	localparam logic [63:0] NS_PER_S = 64'd1000000000;
	localparam logic [63:0] HALF_S = 64'd500000000;
	localparam int unsigned DIV_W = 64;

	// snap a raw rate to the source table; rates beyond 7 bits never snap
	function automatic logic [RATE_W-1:0] snap_src(input logic [DIV_W-1:0] raw);
		logic [RATE_W-1:0] r;
		r = '0;
		if (raw >= 64'd25 && raw <= 64'd35) r = 7'd30;
		else if (raw >= 64'd55 && raw <= 64'd65) r = 7'd60;
		else if (raw >= 64'd66 && raw <= 64'd77) r = 7'd72;
		else if (raw >= 64'd78 && raw <= 64'd95) r = 7'd90;
		else if (raw >= 64'd96 && raw <= 64'd125) r = 7'd120;
		else if (raw >= 64'd36 && raw <= 64'd54) r = 7'd60;
		return r;
	endfunction

	// skip count for a source rate and preferred rate (small table per rate)
	function automatic logic [SKIP_W-1:0] calc_skip(input logic [RATE_W-1:0] rate,
			input logic [PREF_W-1:0] pref);
		logic [SKIP_W-1:0] s;
		logic [PREF_W-1:0] d0, d1, d2, d3, d4, d5, d6, d7;
		logic [3:0] n;
		logic [PREF_W-1:0] chosen;
		logic [3:0] k;
		logic [PREF_W-1:0] lo, hi;
		s = 5'd1;
		d0 = '0; d1 = '0; d2 = '0; d3 = '0; d4 = '0; d5 = '0; d6 = '0; d7 = '0;
		n = 4'd0;
		chosen = '0;
		k = '0;
		lo = '0;
		hi = '0;
		// ascending divisors >= 5 of each source rate
		case (rate)
			7'd30: begin d0 = 8'd5; d1 = 8'd6; d2 = 8'd10; d3 = 8'd15; d4 = 8'd30; n = 4'd5; end
			7'd60: begin d0 = 8'd5; d1 = 8'd6; d2 = 8'd10; d3 = 8'd12; d4 = 8'd15;
				d5 = 8'd20; d6 = 8'd30; d7 = 8'd60; n = 4'd8; end
			7'd72: begin d0 = 8'd6; d1 = 8'd8; d2 = 8'd9; d3 = 8'd12; d4 = 8'd18;
				d5 = 8'd24; d6 = 8'd36; d7 = 8'd72; n = 4'd8; end
			7'd90: begin d0 = 8'd5; d1 = 8'd6; d2 = 8'd9; d3 = 8'd10; d4 = 8'd15;
				d5 = 8'd18; d6 = 8'd30; d7 = 8'd45; n = 4'd8; end
			7'd120: begin d0 = 8'd5; d1 = 8'd6; d2 = 8'd8; d3 = 8'd10; d4 = 8'd12;
				d5 = 8'd15; d6 = 8'd20; d7 = 8'd24; n = 4'd8; end
			default: n = 4'd0;
		endcase
		if (pref == '0 || n == 4'd0) return 5'd1;
		// 90 has 90 too, 120 has 30,40,60,120: handle the top end separately
		if (rate == 7'd90 && pref > 8'd45) begin
			lo = 8'd45; hi = 8'd90;
			chosen = (pref - lo < hi - pref && pref - lo <= 8'd5) ? lo : hi;
		end else if (rate == 7'd120 && pref > 8'd24) begin
			if (pref <= 8'd30) begin lo = 8'd24; hi = 8'd30; end
			else if (pref <= 8'd40) begin lo = 8'd30; hi = 8'd40; end
			else if (pref <= 8'd60) begin lo = 8'd40; hi = 8'd60; end
			else if (pref <= 8'd120) begin lo = 8'd60; hi = 8'd120; end
			else begin lo = 8'd120; hi = 8'd0; end
			if (hi == 8'd0) chosen = (pref - lo <= 8'd5) ? lo : 8'd0;
			else if (pref == hi) chosen = hi;
			else chosen = (pref - lo < hi - pref && pref - lo <= 8'd5) ? lo : hi;
		end else begin
			if (pref <= d0) chosen = (d0 - pref <= 8'd5) ? d0 : 8'd0;
			else begin
				k = 4'd1;
				if (pref > d1 && n > 4'd2) k = 4'd2;
				if (pref > d2 && n > 4'd3) k = 4'd3;
				if (pref > d3 && n > 4'd4) k = 4'd4;
				if (pref > d4 && n > 4'd5) k = 4'd5;
				if (pref > d5 && n > 4'd6) k = 4'd6;
				if (pref > d6 && n > 4'd7) k = 4'd7;
				case (k)
					4'd1: begin lo = d0; hi = d1; end
					4'd2: begin lo = d1; hi = d2; end
					4'd3: begin lo = d2; hi = d3; end
					4'd4: begin lo = d3; hi = d4; end
					4'd5: begin lo = d4; hi = d5; end
					4'd6: begin lo = d5; hi = d6; end
					default: begin lo = d6; hi = d7; end
				endcase
				if (pref > hi) chosen = (pref - hi <= 8'd5) ? hi : 8'd0;
				else if (pref == hi) chosen = hi;
				else chosen = (pref - lo < hi - pref && pref - lo <= 8'd5) ? lo : hi;
			end
		end
		if (chosen == '0) return 5'd1;
		case ({rate, chosen})
			{7'd30, 8'd5}: s = 5'd6;   {7'd30, 8'd6}: s = 5'd5;
			{7'd30, 8'd10}: s = 5'd3;  {7'd30, 8'd15}: s = 5'd2;
			{7'd60, 8'd5}: s = 5'd12;  {7'd60, 8'd6}: s = 5'd10;
			{7'd60, 8'd10}: s = 5'd6;  {7'd60, 8'd12}: s = 5'd5;
			{7'd60, 8'd15}: s = 5'd4;  {7'd60, 8'd20}: s = 5'd3;
			{7'd60, 8'd30}: s = 5'd2;
			{7'd72, 8'd6}: s = 5'd12;  {7'd72, 8'd8}: s = 5'd9;
			{7'd72, 8'd9}: s = 5'd8;   {7'd72, 8'd12}: s = 5'd6;
			{7'd72, 8'd18}: s = 5'd4;  {7'd72, 8'd24}: s = 5'd3;
			{7'd72, 8'd36}: s = 5'd2;
			{7'd90, 8'd5}: s = 5'd18;  {7'd90, 8'd6}: s = 5'd15;
			{7'd90, 8'd9}: s = 5'd10;  {7'd90, 8'd10}: s = 5'd9;
			{7'd90, 8'd15}: s = 5'd6;  {7'd90, 8'd18}: s = 5'd5;
			{7'd90, 8'd30}: s = 5'd3;  {7'd90, 8'd45}: s = 5'd2;
			{7'd120, 8'd5}: s = 5'd24; {7'd120, 8'd6}: s = 5'd20;
			{7'd120, 8'd8}: s = 5'd15; {7'd120, 8'd10}: s = 5'd12;
			{7'd120, 8'd12}: s = 5'd10; {7'd120, 8'd15}: s = 5'd8;
			{7'd120, 8'd20}: s = 5'd6; {7'd120, 8'd24}: s = 5'd5;
			{7'd120, 8'd30}: s = 5'd4; {7'd120, 8'd40}: s = 5'd3;
			{7'd120, 8'd60}: s = 5'd2;
			default: s = 5'd1;
		endcase
		return s;
	endfunction
endpackage

// ----- rtl/core/vfsd_divider.sv -----
// vfsd_divider: restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on vfsd_pkg for the operand width.
`timescale 1ns / 1ps
module vfsd_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vfsd_pkg::DIV_W-1:0]    dividend,
	input  logic [vfsd_pkg::DIV_W-1:0]    divisor,
	output logic                          done,
	output logic [vfsd_pkg::DIV_W-1:0]    quotient,
	output logic [vfsd_pkg::DIV_W-1:0]    remainder
);
	localparam int unsigned W = vfsd_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	// shift one dividend bit in and subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	ap_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider count empty while busy");
endmodule

// ----- rtl/core/vsync_frame_skip_divider.sv -----
// vsync_frame_skip_divider: top level, sequencer around one shared serial divider.
// Depends on vfsd_pkg and vfsd_divider.
`timescale 1ns / 1ps
// Usage:
//  One vsync event word enters on the input channel (stamp_ns, period_ns,
//  sync_enable) with in_valid/in_ready; one result word (skip_frame,
//  next_frame_ns) leaves on out_valid/out_ready for every event.
//  Configuration: cfg_we with cfg_index 0 writes preferred_rate, index 1
//  writes animate_mode; write only while the block is idle.
//  An ignored event answers straight from the decide state. Each division
//  works through 64 quotient bits between load and hand-back. A plain-mode
//  event runs the counter modulo only, or with a changed period the rate
//  and then the modulo. An animate-mode event runs up to five divisions (base
//  of the counter, elapsed ticks, rate, modulo, next time) plus a shift-add
//  product of the elapsed time and the rate.
//  One event is worked on at a time; the result is held in an output
//  register and the next event is taken only in the cycle after that result
//  has been accepted.
//  Reset clears the control state: skip count 1, registers 0, no result pending.
//  When the receiver stalls, the result stays put and the block stops
//  after finishing the event it already took.
module vsync_frame_skip_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [vfsd_pkg::STAMP_W-1:0]      stamp_ns,
	input  logic [vfsd_pkg::PERIOD_W-1:0]     period_ns,
	input  logic                              sync_enable,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              skip_frame,
	output logic [vfsd_pkg::STAMP_W-1:0]      next_frame_ns,
	input  logic                              cfg_we,
	input  logic [vfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vfsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int unsigned W = vfsd_pkg::DIV_W;
	localparam int unsigned RW = vfsd_pkg::RATE_W;
	localparam int unsigned SW = vfsd_pkg::SKIP_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECIDE = 4'd1;
	localparam logic [3:0] ST_MUL    = 4'd2;
	localparam logic [3:0] ST_TICKS  = 4'd3;
	localparam logic [3:0] ST_RATE   = 4'd4;
	localparam logic [3:0] ST_SKIP   = 4'd5;
	localparam logic [3:0] ST_MOD    = 4'd6;
	localparam logic [3:0] ST_NEXT   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;
	localparam logic [3:0] ST_WAITD  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] ret_q;
	logic [W-1:0] last_stamp_q, tick_q, base_q;
	logic [vfsd_pkg::PERIOD_W-1:0] held_period_q;
	logic [RW-1:0] src_rate_q;
	logic [SW-1:0] skip_cnt_q;
	logic stale_q;
	logic [vfsd_pkg::PREF_W-1:0] pref_q;
	logic anim_q;
	logic [W-1:0] stamp_q, prod_q, mcand_q;
	logic [vfsd_pkg::PERIOD_W-1:0] period_q;
	logic en_q, force_q;
	logic [RW-1:0] mplier_q;
	logic out_valid_q, skip_q;
	logic [W-1:0] next_q;
	logic div_start;
	logic [W-1:0] div_a, div_b, div_quo, div_rem;
	logic div_done;
	logic [W-1:0] sc64;
	logic [W-1:0] delta;
	logic [RW-1:0] new_rate;

	vfsd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	assign sc64 = {{(W-SW){1'b0}}, skip_cnt_q};
	assign delta = div_quo + {{(W-1){1'b0}}, (div_rem >= vfsd_pkg::HALF_S)};
	assign new_rate = vfsd_pkg::snap_src(div_quo);
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;

	// sequence one event through the shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			last_stamp_q <= '0;
			tick_q <= '0;
			held_period_q <= '0;
			src_rate_q <= '0;
			skip_cnt_q <= SW'(1);
			stale_q <= 1'b0;
			pref_q <= '0;
			anim_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == vfsd_pkg::REG_PREFERRED) begin
					if (cfg_data != pref_q) begin
						pref_q <= cfg_data;
						stale_q <= 1'b1;
					end
				end else if (cfg_index == vfsd_pkg::REG_ANIMATE) begin
					anim_q <= cfg_data[0];
				end
			end
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					skip_q <= 1'b0;
					next_q <= '0;
					force_q <= 1'b0;
					if (!en_q) begin
						tick_q <= '0;
						state_q <= ST_OUT;
					end else if (period_q == '0 || last_stamp_q == stamp_q || pref_q == '0) begin
						state_q <= ST_OUT;
					end else if (!anim_q) begin
						tick_q <= tick_q + 1'b1;
						last_stamp_q <= stamp_q;
						state_q <= ST_RATE;
					end else begin
						mcand_q <= stamp_q - last_stamp_q;
						mplier_q <= src_rate_q;
						prod_q <= '0;
						last_stamp_q <= stamp_q;
						div_a <= tick_q;
						div_b <= sc64;
						div_start <= 1'b1;
						ret_q <= ST_MUL;
						state_q <= ST_WAITD;
					end
				end
				ST_MUL: begin
					// base = floor(tick/sc)*sc; then shift-add product bit by bit
					if (ret_q == ST_MUL) begin
						base_q <= tick_q - div_rem;
						ret_q <= ST_IDLE;
					end else if (mplier_q != '0) begin
						if (mplier_q[0]) prod_q <= prod_q + mcand_q;
						mcand_q <= {mcand_q[W-2:0], 1'b0};
						mplier_q <= mplier_q >> 1;
					end else begin
						div_a <= prod_q;
						div_b <= vfsd_pkg::NS_PER_S;
						div_start <= 1'b1;
						ret_q <= ST_TICKS;
						state_q <= ST_WAITD;
					end
				end
				ST_TICKS: begin
					tick_q <= tick_q + delta;
					force_q <= (tick_q + delta - base_q) >= sc64;
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					if (held_period_q != period_q) begin
						held_period_q <= period_q;
						div_a <= vfsd_pkg::NS_PER_S * 2 + {32'd0, period_q};
						div_b <= {31'd0, period_q, 1'b0};
						div_start <= 1'b1;
						ret_q <= ST_SKIP;
						state_q <= ST_WAITD;
					end else begin
						state_q <= ST_SKIP;
						ret_q <= ST_IDLE;
					end
				end
				ST_SKIP: begin
					// ret_q == ST_SKIP means a fresh rate sits in the divider
					if (ret_q == ST_SKIP && new_rate != src_rate_q) begin
						src_rate_q <= new_rate;
						tick_q <= '0;
						stale_q <= 1'b1;
						ret_q <= ST_IDLE;
					end else begin
						if (stale_q) begin
							stale_q <= 1'b0;
							skip_cnt_q <= vfsd_pkg::calc_skip(src_rate_q, pref_q);
						end
						state_q <= ST_MOD;
						ret_q <= ST_IDLE;
					end
				end
				ST_MOD: begin
					if (ret_q == ST_IDLE) begin
						div_a <= tick_q;
						div_b <= sc64;
						div_start <= 1'b1;
						ret_q <= ST_MOD;
						state_q <= ST_WAITD;
					end else begin
						skip_q <= (div_rem != '0) && !force_q;
						if (anim_q && src_rate_q != '0) begin
							// sc - rem fits the skip width since rem < sc
							div_a <= W'(skip_cnt_q - div_rem[SW-1:0]) * vfsd_pkg::NS_PER_S;
							div_b <= {{(W-RW){1'b0}}, src_rate_q};
							div_start <= 1'b1;
							ret_q <= ST_NEXT;
							state_q <= ST_WAITD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_NEXT: begin
					next_q <= last_stamp_q + div_quo;
					state_q <= ST_OUT;
				end
				ST_WAITD: if (div_done) state_q <= ret_q;
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the accepted event word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			stamp_q <= stamp_ns;
			period_q <= period_ns;
			en_q <= sync_enable;
		end
	end

	assign out_valid = out_valid_q;
	assign skip_frame = skip_q;
	assign next_frame_ns = next_q;

	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready) else $error("input taken while result pending");
	ap_skip_nz: assert property (@(posedge clk) disable iff (!arst_n)
		skip_cnt_q != '0) else $error("skip count zero");
	ap_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid_q) else $error("result not raised");
	ap_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> state_q == ST_WAITD) else $error("divider start outside wait");
endmodule
